[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the shortest path block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define APSP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define APSP_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define APSP_ASSERT(lbl, clk, rstn, prop, msg)
`define APSP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[sv/apsp_pkg.sv]
// Types and constants of the all-pairs shortest path block
package apsp_pkg;
    localparam int MAX_V      = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int DIST_W     = 32;
    localparam int WEIGHT_W   = 24;
    localparam int RESULT_CAP = 16;

    localparam logic       CMD_LOAD    = 1'b0;
    localparam logic       CMD_QUERY   = 1'b1;
    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_VERTEX = 2'd1;
    localparam logic [1:0] KIND_NOPATH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RELAX,
        ST_QREAD,
        ST_QEMIT
    } state_t;

    // common controls broadcast to every cell
    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              ld_en;
        logic [IDX_W-1:0]  ld_row;
        logic [IDX_W-1:0]  ld_col;
        logic [DIST_W-1:0] ld_dist;
        logic              ld_reach;
        logic              piv_cap;
        logic              proc_en;
        logic [IDX_W-1:0]  proc_row;
        logic [IDX_W-1:0]  col_max;
        logic [DIST_W-1:0] dik;
        logic [IDX_W-1:0]  hik;
        logic              rik;
    } cell_ctrl_t;

    // registered read data of one cell
    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic [IDX_W-1:0]  hop;
        logic              reach;
    } cell_rd_t;
endpackage

[sv/apsp_cell.sv]
// One column cell: column storage, pivot-row entry and relaxation compare
module apsp_cell #(
    parameter int COL = 0
) (
    input  logic                clk,
    input  apsp_pkg::cell_ctrl_t ctrl,
    output apsp_pkg::cell_rd_t   rd
);
    import apsp_pkg::*;

    localparam logic [IDX_W-1:0] COL_IDX = IDX_W'(COL);

    logic [DIST_W-1:0] dist_mem  [MAX_V];
    logic [IDX_W-1:0]  hop_mem   [MAX_V];
    logic              reach_mem [MAX_V];

    logic [DIST_W-1:0] piv_dist_reg;
    logic              piv_reach_reg;

    logic              we;
    logic [IDX_W-1:0]  wa;
    logic [DIST_W-1:0] wdist;
    logic [IDX_W-1:0]  whop;
    logic              wreach;
    logic [DIST_W:0]   sum;
    logic              better;

    // candidate path through the pivot
    assign sum    = {1'b0, ctrl.dik} + {1'b0, piv_dist_reg};
    assign better = ctrl.rik && piv_reach_reg && (!rd.reach || sum < {1'b0, rd.dist_val});

    // write port: edge load or relaxation update (columns in use only)
    always_comb
    begin
        if (ctrl.ld_en)
        begin
            we     = (ctrl.ld_col == COL_IDX);
            wa     = ctrl.ld_row;
            wdist  = ctrl.ld_dist;
            whop   = COL_IDX;
            wreach = ctrl.ld_reach;
        end
        else
        begin
            we     = ctrl.proc_en && better && (COL_IDX <= ctrl.col_max);
            wa     = ctrl.proc_row;
            wdist  = sum[DIST_W-1:0];
            whop   = ctrl.hik;
            wreach = 1'b1;
        end
    end

    // column memory with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            dist_mem[wa]  <= wdist;
            hop_mem[wa]   <= whop;
            reach_mem[wa] <= wreach;
        end
        rd.dist_val <= dist_mem[ctrl.rd_addr];
        rd.hop      <= hop_mem[ctrl.rd_addr];
        rd.reach    <= reach_mem[ctrl.rd_addr];
    end

    // pivot row entry held for one phase
    always_ff @(posedge clk)
    begin
        if (ctrl.piv_cap)
        begin
            piv_dist_reg  <= rd.dist_val;
            piv_reach_reg <= rd.reach;
        end
    end
endmodule

[sv/all_pairs_shortest_path.sv]
// Top level: request sequencer, row of column cells and result register
// Load without last: taken, no result; a load request follows every cycle.
// Load with last: per pivot, relaxation reads the pivot row, captures it, then updates the n rows
// (one memory read port per cell); the done result follows in the cycle after the last row.
// Query: a cell read state and an emit state per path vertex; a range miss answers in the next cycle.
// Results strobe for one cycle, no stall; async reset clears control and sets vertex_count to 16.
module all_pairs_shortest_path (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [4:0]                     cfg_wr_data,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [apsp_pkg::IDX_W-1:0]     row,
    input  logic [apsp_pkg::IDX_W-1:0]     col,
    input  logic [apsp_pkg::WEIGHT_W-1:0]  weight,
    input  logic                           no_edge,
    input  logic                           load_last,
    input  logic [apsp_pkg::IDX_W-1:0]     from_vertex,
    input  logic [apsp_pkg::IDX_W-1:0]     to_vertex,
    output logic                           result_strobe,
    output logic [1:0]                     kind,
    output logic [apsp_pkg::IDX_W-1:0]     vertex,
    output logic                           path_last
);
    import apsp_pkg::*;
    `include "assert_macros.svh"

    state_t            state_reg, state_next;
    logic [4:0]        vc_reg;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  s_reg, s_next;
    logic [IDX_W-1:0]  u_reg, u_next;
    logic [IDX_W-1:0]  v_reg, v_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              first_reg, first_next;
    logic              strobe_reg, strobe_next;
    logic [1:0]        kind_reg, kind_next;
    logic [IDX_W-1:0]  vertex_reg, vertex_next;
    logic              last_reg, last_next;

    logic [CNT_W-1:0]  n;
    logic [IDX_W-1:0]  n_m1;
    logic              accept;
    cell_ctrl_t        ctrl;
    cell_rd_t          rd_all [MAX_V];
    cell_rd_t          sel_rd;
    logic [IDX_W-1:0]  sel_col;
    logic [IDX_W-1:0]  hop_clamped;

    // vertices in use, clamped to 1..MAX_V
    always_comb
    begin
        if (vc_reg == 5'd0)
            n = CNT_W'(1);
        else if (vc_reg > CNT_W'(MAX_V))
            n = CNT_W'(MAX_V);
        else
            n = vc_reg;
    end
    assign n_m1 = IDX_W'(n - CNT_W'(1));

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // column select: pivot column while relaxing, target column on a walk
    assign sel_col     = (state_reg == ST_RELAX) ? k_reg : v_reg;
    assign sel_rd      = rd_all[sel_col];
    assign hop_clamped = ({1'b0, sel_rd.hop} >= n) ? n_m1 : sel_rd.hop;

    // cell controls
    always_comb
    begin
        ctrl.ld_en    = accept && (cmd == CMD_LOAD) && ({1'b0, row} < n) && ({1'b0, col} < n);
        ctrl.ld_row   = row;
        ctrl.ld_col   = col;
        ctrl.ld_dist  = no_edge ? '0 : DIST_W'(weight);
        ctrl.ld_reach = !no_edge;
        ctrl.piv_cap  = (state_reg == ST_RELAX) && (s_reg == CNT_W'(1));
        ctrl.proc_en  = (state_reg == ST_RELAX) && (s_reg >= CNT_W'(2));
        ctrl.proc_row = IDX_W'(s_reg - CNT_W'(2));
        ctrl.col_max  = n_m1;
        ctrl.dik      = sel_rd.dist_val;
        ctrl.hik      = sel_rd.hop;
        ctrl.rik      = sel_rd.reach;
        if (state_reg == ST_RELAX)
            ctrl.rd_addr = (s_reg == '0) ? k_reg : IDX_W'(s_reg - CNT_W'(1));
        else
            ctrl.rd_addr = u_reg;
    end

    // row of column cells
    for (genvar j = 0; j < MAX_V; j++)
    begin : g_cell
        apsp_cell #(.COL(j)) u_cell (
            .clk  (clk),
            .ctrl (ctrl),
            .rd   (rd_all[j])
        );
    end

    // sequencer next state and result
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        s_next      = s_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        vertex_next = vertex_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        if (load_last)
                        begin
                            state_next = ST_RELAX;
                            k_next     = '0;
                            s_next     = '0;
                        end
                    end
                    else if (({1'b0, from_vertex} >= n) || ({1'b0, to_vertex} >= n))
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_NOPATH;
                        vertex_next = '0;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_QREAD;
                        u_next     = from_vertex;
                        v_next     = to_vertex;
                        cnt_next   = '0;
                        first_next = 1'b1;
                    end
                end
            end
            ST_RELAX:
            begin
                if (s_reg == n + CNT_W'(1))
                begin
                    s_next = '0;
                    if (k_reg == n_m1)
                    begin
                        state_next  = ST_IDLE;
                        strobe_next = 1'b1;
                        kind_next   = KIND_DONE;
                        vertex_next = '0;
                        last_next   = 1'b1;
                    end
                    else
                        k_next = k_reg + IDX_W'(1);
                end
                else
                    s_next = s_reg + CNT_W'(1);
            end
            ST_QREAD:
            begin
                state_next = ST_QEMIT;
            end
            ST_QEMIT:
            begin
                strobe_next = 1'b1;
                if (first_reg && !sel_rd.reach)
                begin
                    state_next  = ST_IDLE;
                    kind_next   = KIND_NOPATH;
                    vertex_next = '0;
                    last_next   = 1'b1;
                end
                else
                begin
                    kind_next   = KIND_VERTEX;
                    vertex_next = u_reg;
                    first_next  = 1'b0;
                    if ((u_reg == v_reg) || (cnt_reg == IDX_W'(RESULT_CAP - 1)))
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        u_next     = hop_clamped;
                        cnt_next   = cnt_reg + IDX_W'(1);
                        state_next = ST_QREAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vc_reg     <= 5'd16;
            k_reg      <= '0;
            s_reg      <= '0;
            cnt_reg    <= '0;
            first_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            s_reg      <= s_next;
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
            strobe_reg <= strobe_next;
            if (cfg_wr_en)
                vc_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        v_reg      <= v_next;
        kind_reg   <= kind_next;
        vertex_reg <= vertex_next;
        last_reg   <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign vertex        = vertex_reg;
    assign path_last     = last_reg;

    `APSP_ASSERT(a_done_after_relax, clk, rst_n, (strobe_reg && kind_reg == KIND_DONE) |-> $past(state_reg == ST_RELAX), "done result without relaxation")
    `APSP_NEVER(a_kind_legal, clk, rst_n, strobe_reg && !(kind_reg == KIND_DONE || kind_reg == KIND_VERTEX || kind_reg == KIND_NOPATH), "illegal result kind")
    `APSP_ASSERT(a_walk_in_range, clk, rst_n, (state_reg == ST_QEMIT) |-> ({1'b0, u_reg} < n && {1'b0, v_reg} < n), "walk vertex out of range")
    `APSP_ASSERT(a_step_bound, clk, rst_n, (state_reg == ST_RELAX) |-> (s_reg <= n + CNT_W'(1)), "relax step past row sweep")
    `APSP_ASSERT(a_last_ends, clk, rst_n, (strobe_reg && !last_reg) |-> (state_reg == ST_QREAD), "unfinished walk not continuing")
endmodule

[tb/sv/tb_all_pairs_shortest_path.sv]
// Testbench for the all-pairs shortest path block: load, relax and path query checks
`timescale 1ns / 1ps

module tb_all_pairs_shortest_path;
    import apsp_pkg::*;

    typedef struct {
        logic                cmd;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [WEIGHT_W-1:0] weight;
        logic                no_edge;
        logic                load_last;
        logic [IDX_W-1:0]    from_v;
        logic [IDX_W-1:0]    to_v;
    } request_t;

    typedef struct {
        logic [1:0]       kind;
        logic [IDX_W-1:0] vertex;
        logic             last;
    } path_result_t;

    // Shortest path predictor plus queue of expected results
    class path_scoreboard;
        bit [DIST_W-1:0] dist_tab[MAX_V*MAX_V];
        bit [IDX_W-1:0]  hop_tab[MAX_V*MAX_V];
        bit              reach_tab[MAX_V*MAX_V];
        int unsigned     vcount = 16;
        path_result_t    expected_paths[$];
        int              errors = 0;

        function int unsigned active_vertices();
            int unsigned n;
            n = vcount;
            if (n < 1) n = 1;
            if (n > MAX_V) n = MAX_V;
            return n;
        endfunction

        function void set_vertex_count(bit [4:0] v);
            vcount = v;
        endfunction

        function void push(logic [1:0] k, logic [IDX_W-1:0] v, logic l);
            path_result_t r;
            r.kind = k;
            r.vertex = v;
            r.last = l;
            expected_paths.insert(expected_paths.size(), r);
        endfunction

        // Floyd-Warshall over the vertices in use
        function void relax_all(int unsigned n);
            bit [DIST_W:0] sum;
            for (int k = 0; k < n; k++)
                for (int i = 0; i < n; i++)
                begin
                    if (!reach_tab[i*MAX_V+k]) continue;
                    for (int j = 0; j < n; j++)
                    begin
                        if (!reach_tab[k*MAX_V+j]) continue;
                        sum = dist_tab[i*MAX_V+k] + dist_tab[k*MAX_V+j];
                        if (!reach_tab[i*MAX_V+j] || sum < {1'b0, dist_tab[i*MAX_V+j]})
                        begin
                            dist_tab[i*MAX_V+j] = sum[DIST_W-1:0];
                            hop_tab[i*MAX_V+j] = hop_tab[i*MAX_V+k];
                            reach_tab[i*MAX_V+j] = 1'b1;
                        end
                    end
                end
        endfunction

        // Note one accepted request and queue what it should produce
        function void note_request(request_t q);
            int unsigned n;
            int unsigned u;
            int unsigned v;
            int          cnt;
            bit          done;
            n = active_vertices();
            if (q.cmd == CMD_LOAD)
            begin
                if (q.row < n && q.col < n)
                begin
                    dist_tab[q.row*MAX_V+q.col] = q.no_edge ? '0 : DIST_W'(q.weight);
                    hop_tab[q.row*MAX_V+q.col] = q.col;
                    reach_tab[q.row*MAX_V+q.col] = !q.no_edge;
                end
                if (q.load_last)
                begin
                    relax_all(n);
                    push(KIND_DONE, '0, 1'b1);
                end
            end
            else
            begin
                u = q.from_v;
                v = q.to_v;
                if (u >= n || v >= n || !reach_tab[u*MAX_V+v])
                begin
                    push(KIND_NOPATH, '0, 1'b1);
                    return;
                end
                cnt = 0;
                forever
                begin
                    done = (u == v) || (cnt == RESULT_CAP - 1);
                    push(KIND_VERTEX, IDX_W'(u), done);
                    cnt++;
                    if (done) break;
                    u = hop_tab[u*MAX_V+v];
                    if (u >= n) u = n - 1;
                end
            end
        endfunction

        function void check_result(logic [1:0] k, logic [IDX_W-1:0] v, logic l);
            path_result_t e;
            if (expected_paths.size() == 0)
            begin
                $error("unexpected result: kind %0d vertex %0d last %0d", k, v, l);
                errors++;
                return;
            end
            e = expected_paths.pop_front();
            if (k !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, k);
                errors++;
            end
            if (v !== e.vertex)
            begin
                $error("vertex: expected %0d, actual %0d", e.vertex, v);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("path_last: expected %0d, actual %0d", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [4:0]          cfg_wr_data;
    logic                start;
    logic                busy;
    logic                cmd;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [WEIGHT_W-1:0] weight;
    logic                no_edge;
    logic                load_last;
    logic [IDX_W-1:0]    from_vertex;
    logic [IDX_W-1:0]    to_vertex;
    logic                result_strobe;
    logic [1:0]          kind;
    logic [IDX_W-1:0]    vertex;
    logic                path_last;

    path_scoreboard sb = new();
    int burst_left = 0;

    all_pairs_shortest_path dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .start(start), .busy(busy),
        .cmd(cmd), .row(row), .col(col), .weight(weight),
        .no_edge(no_edge), .load_last(load_last),
        .from_vertex(from_vertex), .to_vertex(to_vertex),
        .result_strobe(result_strobe), .kind(kind),
        .vertex(vertex), .path_last(path_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_result(kind, vertex, path_last);
    end

    // Issue one request, with bursty gaps between requests
    task automatic send(request_t q);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 5) == 0) burst_left = 40;
        end
        burst_left--;
        cmd <= q.cmd;
        row <= q.row;
        col <= q.col;
        weight <= q.weight;
        no_edge <= q.no_edge;
        load_last <= q.load_last;
        from_vertex <= q.from_v;
        to_vertex <= q.to_v;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_request(q);
    endtask

    // Hold off until every expected result is back, then let the block settle
    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (sb.expected_paths.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vertex_count(bit [4:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_vertex_count(v);
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WEIGHT_W'($urandom);
            default: return WEIGHT_W'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic request_t junk_request(logic c);
        request_t q;
        q.cmd = c;
        q.row = IDX_W'($urandom);
        q.col = IDX_W'($urandom);
        q.weight = WEIGHT_W'($urandom);
        q.no_edge = 1'($urandom);
        q.load_last = 1'($urandom);
        q.from_v = IDX_W'($urandom);
        q.to_v = IDX_W'($urandom);
        return q;
    endfunction

    // Load the whole square in use, chain_only keeps just the edges from each vertex to the next
    task automatic load_square(int n, bit chain_only, bit last_out_of_range);
        request_t q;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                // stray out-of-range load, writes nothing
                if (n < MAX_V && $urandom_range(0, 7) == 0)
                begin
                    q = junk_request(CMD_LOAD);
                    q.row = IDX_W'($urandom_range(n, MAX_V - 1));
                    q.load_last = 1'b0;
                    send(q);
                end
                q = junk_request(CMD_LOAD);
                q.row = IDX_W'(r);
                q.col = IDX_W'(c);
                q.weight = pick_weight();
                q.no_edge = chain_only ? (c != r + 1) : ($urandom_range(0, 3) == 0);
                q.load_last = (r == n - 1 && c == n - 1 && !last_out_of_range);
                send(q);
            end
        if (last_out_of_range)
        begin
            q = junk_request(CMD_LOAD);
            q.col = IDX_W'($urandom_range(n, MAX_V - 1));
            q.load_last = 1'b1;
            send(q);
        end
    endtask

    task automatic query(int f, int t);
        request_t q;
        q = junk_request(CMD_QUERY);
        q.from_v = IDX_W'(f);
        q.to_v = IDX_W'(t);
        send(q);
    endtask

    task automatic random_queries(int n, int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                query($urandom_range(0, 15), $urandom_range(0, 15));
            else
                query($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        end
    endtask

    // Main sequence
    initial
    begin
        bit [4:0] counts[6];
        int n;
        counts = '{5'd1, 5'd0, 5'd2, 5'd3, 5'd5, 5'd4};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        start = 1'b0;
        cmd = CMD_LOAD;
        row = '0;
        col = '0;
        weight = '0;
        no_edge = 1'b0;
        load_last = 1'b0;
        from_vertex = '0;
        to_vertex = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full size chain: longest walk, reverse miss, diagonal without edge
        write_vertex_count(5'd16);
        load_square(16, 1'b1, 1'b0);
        query(0, 15);
        query(15, 0);
        query(3, 3);
        query(2, 9);
        random_queries(16, 6);

        // Count above range clamps to full size, tables stay valid
        write_vertex_count(5'd31);
        query(0, 15);
        random_queries(16, 6);

        // Small graphs with random weights
        foreach (counts[p])
        begin
            write_vertex_count(counts[p]);
            n = (counts[p] == 0) ? 1 : counts[p];
            load_square(n, 1'b0, (p % 3) == 1);
            query(n - 1, n - 1);
            query(0, 15);
            random_queries(n, 5);
        end

        drain();
        if (sb.errors == 0 && sb.expected_paths.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
